// ===== rtl/bsim_pkg.sv =====
// bsim_pkg: shared constants and register codes for the broadcast source index map
// no dependencies; imported by every module of the block
`default_nettype none

package bsim_pkg;

  // fixed widths of the configuration port and of the result word
  localparam int SRC_BITS     = 64;
  localparam int RANK_BITS    = 3;
  localparam int CFG_IDX_BITS = 2;

  // defaults of the top-level parameters
  localparam int MAX_RANK_DEF    = 4;
  localparam int EXTENT_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF  = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RESULT_RANK    = 2'd0,
    CFG_SOURCE_RANK    = 2'd1,
    CFG_RESULT_EXTENTS = 2'd2,
    CFG_SOURCE_EXTENTS = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/broadcast_source_index_map_top.sv =====
// Structure: one input register, then per axis one division cell per index bit
// and one multiply-add cell, from accepted word to result word. Throughput: one
// word per cycle; the whole chain advances unless a result waits with out_stall
// high.
// Reset: synchronous, active low; ranks go to one, every extent to one,
// the pipeline empties. Derived axis weights settle slot by slot after a write.
`default_nettype none

module broadcast_source_index_map_top #(
  parameter int MAX_RANK    = bsim_pkg::MAX_RANK_DEF,
  parameter int EXTENT_BITS = bsim_pkg::EXTENT_BITS_DEF,
  parameter int INDEX_BITS  = bsim_pkg::INDEX_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bsim_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  wire logic [bsim_pkg::SRC_BITS-1:0]     cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [INDEX_BITS-1:0]             in_result_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bsim_pkg::SRC_BITS-1:0]          out_source_index
);
  import bsim_pkg::*;

  localparam int NSTG = MAX_RANK * (INDEX_BITS + 1);

  // packed ones in every extent field that lies inside the register
  function automatic logic [SRC_BITS-1:0] ones_packed();
    logic [SRC_BITS-1:0] v;
    v = '0;
    for (int a = 0; a < MAX_RANK; a++) begin
      if (a * EXTENT_BITS < SRC_BITS) begin
        v[a*EXTENT_BITS] = 1'b1;
      end
    end
    return v;
  endfunction

  // one extent field, zero and missing fields read as one
  function automatic logic [EXTENT_BITS-1:0] extent_at(logic [SRC_BITS-1:0] pk, int axis);
    int                  pos;
    logic [SRC_BITS-1:0] sh;
    logic [EXTENT_BITS-1:0] e;
    pos = axis * EXTENT_BITS;
    sh  = pk >> pos;
    e   = sh[EXTENT_BITS-1:0];
    if (pos >= SRC_BITS || e == '0) begin
      e = {{(EXTENT_BITS-1){1'b0}}, 1'b1};
    end
    return e;
  endfunction

  // configuration registers
  logic [RANK_BITS-1:0] result_rank_r;
  logic [RANK_BITS-1:0] source_rank_r;
  logic [SRC_BITS-1:0]  result_extents_r;
  logic [SRC_BITS-1:0]  source_extents_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      result_rank_r    <= RANK_BITS'(1);
      source_rank_r    <= RANK_BITS'(1);
      result_extents_r <= ones_packed();
      source_extents_r <= ones_packed();
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        CFG_RESULT_RANK:    result_rank_r    <= cfg_wdata[RANK_BITS-1:0];
        CFG_SOURCE_RANK:    source_rank_r    <= cfg_wdata[RANK_BITS-1:0];
        CFG_RESULT_EXTENTS: result_extents_r <= cfg_wdata;
        CFG_SOURCE_EXTENTS: source_extents_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective ranks
  int rr_eff;
  int sr_eff;
  int offset;

  always_comb begin
    rr_eff = int'(result_rank_r);
    if (rr_eff == 0) rr_eff = 1;
    if (rr_eff > MAX_RANK) rr_eff = MAX_RANK;
    sr_eff = int'(source_rank_r);
    if (sr_eff > rr_eff) sr_eff = rr_eff;
    offset = rr_eff - sr_eff;
  end

  // per-slot divisor and source weight; slot s walks axis rr-1-s
  logic [EXTENT_BITS-1:0] rext_r   [MAX_RANK];
  logic [SRC_BITS-1:0]    weight_r [MAX_RANK];
  logic [SRC_BITS-1:0]    ssuf_r   [MAX_RANK];

  for (genvar s = 0; s < MAX_RANK; s++) begin : g_slot
    logic                   active;
    logic                   in_src;
    int                     axis;
    logic [EXTENT_BITS-1:0] sext;
    logic [EXTENT_BITS-1:0] rext_nxt;
    logic [SRC_BITS-1:0]    weight_nxt;
    logic [SRC_BITS-1:0]    ssuf_in;
    logic [SRC_BITS-1:0]    ssuf_nxt;

    // running source suffix product entering this slot
    if (s == 0) begin : g_first
      assign ssuf_in = {{(SRC_BITS-1){1'b0}}, 1'b1};
    end else begin : g_next
      assign ssuf_in = ssuf_r[s-1];
    end

    always_comb begin
      axis       = rr_eff - 1 - s;
      active     = s < rr_eff;
      in_src     = active && (axis >= offset);
      sext       = extent_at(source_extents_r, axis - offset);
      rext_nxt   = active ? extent_at(result_extents_r, axis)
                          : {{(EXTENT_BITS-1){1'b0}}, 1'b1};
      weight_nxt = (in_src && sext != {{(EXTENT_BITS-1){1'b0}}, 1'b1}) ? ssuf_in : '0;
      ssuf_nxt   = in_src ? SRC_BITS'(ssuf_in * {{(SRC_BITS-EXTENT_BITS){1'b0}}, sext})
                          : ssuf_in;
    end

    always_ff @(posedge clk) begin
      rext_r[s]   <= rext_nxt;
      weight_r[s] <= weight_nxt;
      ssuf_r[s]   <= ssuf_nxt;
    end
  end

  // pipeline advance
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  logic                   vld [NSTG+1];
  logic [INDEX_BITS-1:0]  quo [NSTG+1];
  logic [EXTENT_BITS-1:0] rem [NSTG+1];
  logic [SRC_BITS-1:0]    acc [NSTG+1];

  // input register
  logic                  in_vld_r;
  logic [INDEX_BITS-1:0] in_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_idx_r <= in_result_index;
    end
  end

  assign vld[0] = in_vld_r;
  assign quo[0] = in_idx_r;
  assign rem[0] = '0;
  assign acc[0] = '0;

  // chain: per slot INDEX_BITS division cells then one multiply-add cell
  for (genvar s = 0; s < MAX_RANK; s++) begin : g_chain
    for (genvar b = 0; b < INDEX_BITS; b++) begin : g_bit
      localparam int K = s * (INDEX_BITS + 1) + b;
      bsim_div_cell #(
        .INDEX_BITS  (INDEX_BITS),
        .EXTENT_BITS (EXTENT_BITS)
      ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .divisor (rext_r[s]),
        .vld_in  (vld[K]),
        .quo_in  (quo[K]),
        .rem_in  (rem[K]),
        .acc_in  (acc[K]),
        .vld_r   (vld[K+1]),
        .quo_r   (quo[K+1]),
        .rem_r   (rem[K+1]),
        .acc_r   (acc[K+1])
      );
    end
    localparam int M = s * (INDEX_BITS + 1) + INDEX_BITS;
    bsim_mac_cell #(
      .INDEX_BITS  (INDEX_BITS),
      .EXTENT_BITS (EXTENT_BITS)
    ) u_mac (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .weight (weight_r[s]),
      .vld_in (vld[M]),
      .quo_in (quo[M]),
      .rem_in (rem[M]),
      .acc_in (acc[M]),
      .vld_r  (vld[M+1]),
      .quo_r  (quo[M+1]),
      .rem_r  (rem[M+1]),
      .acc_r  (acc[M+1])
    );
  end

  assign out_valid        = vld[NSTG];
  assign out_source_index = acc[NSTG];

  // effective result rank stays in range and source rank does not exceed it
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    rr_eff >= 1 && rr_eff <= MAX_RANK && sr_eff <= rr_eff)
    else $error("effective rank out of range");

  // innermost divisor never zero once settled
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> rext_r[0] != '0)
    else $error("zero divisor in first slot");

  // input stage holds still while the result waits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld[0]) && $stable(quo[0]))
    else $error("input stage moved during stall");

endmodule

`default_nettype wire

// ===== rtl/bsim_div_cell.sv =====
// bsim_div_cell: one restoring division step, quotient bit per cell
// depends on bsim_pkg; chained by the top level, one chain of cells per axis
`default_nettype none

module bsim_div_cell #(
  parameter int INDEX_BITS  = bsim_pkg::INDEX_BITS_DEF,
  parameter int EXTENT_BITS = bsim_pkg::EXTENT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic [EXTENT_BITS-1:0]      divisor,
  input  wire logic                        vld_in,
  input  wire logic [INDEX_BITS-1:0]       quo_in,
  input  wire logic [EXTENT_BITS-1:0]      rem_in,
  input  wire logic [bsim_pkg::SRC_BITS-1:0] acc_in,
  output logic                             vld_r,
  output logic [INDEX_BITS-1:0]            quo_r,
  output logic [EXTENT_BITS-1:0]           rem_r,
  output logic [bsim_pkg::SRC_BITS-1:0]    acc_r
);
  import bsim_pkg::*;

  logic [EXTENT_BITS:0]   shifted;
  logic                   ge;
  logic [EXTENT_BITS:0]   diff;
  logic [INDEX_BITS-1:0]  quo_nxt;
  logic [EXTENT_BITS-1:0] rem_nxt;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    shifted = {rem_in, quo_in[INDEX_BITS-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = ge ? (shifted - {1'b0, divisor}) : shifted;
    rem_nxt = diff[EXTENT_BITS-1:0];
    quo_nxt = {quo_in[INDEX_BITS-2:0], ge};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      acc_r <= acc_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bsim_mac_cell.sv =====
// bsim_mac_cell: adds one axis term (coordinate times source weight) to the sum
// depends on bsim_pkg; closes each axis chain of division cells
`default_nettype none

module bsim_mac_cell #(
  parameter int INDEX_BITS  = bsim_pkg::INDEX_BITS_DEF,
  parameter int EXTENT_BITS = bsim_pkg::EXTENT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [bsim_pkg::SRC_BITS-1:0] weight,
  input  wire logic                          vld_in,
  input  wire logic [INDEX_BITS-1:0]         quo_in,
  input  wire logic [EXTENT_BITS-1:0]        rem_in,
  input  wire logic [bsim_pkg::SRC_BITS-1:0] acc_in,
  output logic                               vld_r,
  output logic [INDEX_BITS-1:0]              quo_r,
  output logic [EXTENT_BITS-1:0]             rem_r,
  output logic [bsim_pkg::SRC_BITS-1:0]      acc_r
);
  import bsim_pkg::*;

  logic [SRC_BITS-1:0] coord;
  logic [SRC_BITS-1:0] acc_nxt;

  // remainder is the coordinate of this axis; the sum wraps at the word width
  always_comb begin
    coord   = {{(SRC_BITS-EXTENT_BITS){1'b0}}, rem_in};
    acc_nxt = acc_in + weight * coord;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  // payload; remainder restarts at zero for the next axis
  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_in;
      rem_r <= '0;
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire
